@@ rtl/tceu_pkg.sv @@
// ----------------------------------------------------------------------------
// tceu_pkg
// Shared types, codes and defaults of the toy cpu execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tceu_pkg;

	// defaults of the top level parameters
	localparam int REG_COUNT_DEF      = 16;
	localparam int DATA_MEM_DEPTH_DEF = 256;
	localparam int DATA_WIDTH_DEF     = 32;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// input selector
	localparam logic FUNC_EXEC    = 1'b0;
	localparam logic FUNC_PRELOAD = 1'b1;

	// opcodes
	localparam logic [3:0] OP_LOAD  = 4'h1;
	localparam logic [3:0] OP_STORE = 4'h2;
	localparam logic [3:0] OP_ADD   = 4'h5;
	localparam logic [3:0] OP_SUB   = 4'h6;
	localparam logic [3:0] OP_DIV   = 4'h7;
	localparam logic [3:0] OP_MUL   = 4'h8;

	// result kinds
	localparam logic [1:0] OUT_NONE = 2'd0;
	localparam logic [1:0] OUT_REG  = 2'd1;
	localparam logic [1:0] OUT_MEM  = 2'd2;
	localparam logic [1:0] OUT_DIVZ = 2'd3;

	typedef enum logic [2:0] {
		K_NOP,
		K_PRELOAD,
		K_LOAD,
		K_STORE,
		K_ALU
	} kind_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_DIV,
		ALU_MUL
	} alu_t;

	// decoded item handed from front to back
	typedef struct packed {
		kind_t              kind;
		alu_t               alu;
		logic [3:0]         d;
		logic [3:0]         a;
		logic [3:0]         b;
		logic [7:0]         addr;
		logic signed [31:0] value;
		logic               d_ok;
		logic               a_ok;
		logic               b_ok;
		logic               addr_ok;
	} cmd_t;

	// request to the iterative multiply / divide unit
	typedef struct packed {
		logic start;
		logic is_div;
	} md_req_t;

endpackage

`default_nettype wire

@@ rtl/tceu_ram.sv @@
// ----------------------------------------------------------------------------
// tceu_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tceu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/tceu_front.sv @@
// ----------------------------------------------------------------------------
// tceu_front
// Accepts items, decodes the instruction word and range checks the indexes.
// ----------------------------------------------------------------------------
`default_nettype none

module tceu_front
	import tceu_pkg::*;
#(
	parameter int REG_COUNT      = REG_COUNT_DEF,
	parameter int DATA_MEM_DEPTH = DATA_MEM_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // instr, load_addr, load_value
	input  wire logic [0:0]  s_tuser,  // func
	output logic             push_valid,
	input  wire logic        push_ready,
	output cmd_t             push_cmd
);

	logic       valid_s1;
	cmd_t       cmd_s1;
	cmd_t       dec;
	logic [3:0] op;
	logic [7:0] la;

	assign op = s_tdata[15:12];
	assign la = s_tdata[23:16];

	always_comb begin
		dec         = '0;
		dec.d       = s_tdata[11:8];
		dec.a       = s_tdata[7:4];
		dec.b       = s_tdata[3:0];
		dec.addr    = s_tdata[7:0];
		dec.value   = signed'(s_tdata[55:24]);
		dec.d_ok    = {1'b0, s_tdata[11:8]} < 5'(REG_COUNT);
		dec.a_ok    = {1'b0, s_tdata[7:4]} < 5'(REG_COUNT);
		dec.b_ok    = {1'b0, s_tdata[3:0]} < 5'(REG_COUNT);
		dec.addr_ok = {1'b0, s_tdata[7:0]} < 9'(DATA_MEM_DEPTH);
		dec.kind    = K_NOP;
		dec.alu     = ALU_ADD;
		if (s_tuser[0] == FUNC_PRELOAD) begin
			dec.kind    = K_PRELOAD;
			dec.addr    = la;
			dec.addr_ok = {1'b0, la} < 9'(DATA_MEM_DEPTH);
		end else begin
			case (op)
				OP_LOAD: begin
					dec.kind = K_LOAD;
				end
				OP_STORE: begin
					dec.kind = K_STORE;
				end
				OP_ADD: begin
					dec.kind = K_ALU;
					dec.alu  = ALU_ADD;
				end
				OP_SUB: begin
					dec.kind = K_ALU;
					dec.alu  = ALU_SUB;
				end
				OP_DIV: begin
					dec.kind = K_ALU;
					dec.alu  = ALU_DIV;
				end
				OP_MUL: begin
					dec.kind = K_ALU;
					dec.alu  = ALU_MUL;
				end
				default: begin
					dec.kind = K_NOP;
				end
			endcase
		end
	end

	assign s_tready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= dec;
		end
	end

endmodule

`default_nettype wire

@@ rtl/tceu_fifo.sv @@
// ----------------------------------------------------------------------------
// tceu_fifo
// Short queue of decoded items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tceu_fifo
	import tceu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire cmd_t in_cmd,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      out_cmd
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign in_ready  = count_q != CW'(QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign out_cmd   = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

`default_nettype wire

@@ rtl/tceu_muldiv.sv @@
// ----------------------------------------------------------------------------
// tceu_muldiv
// Iterative shift-add multiplier and restoring signed divider, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tceu_muldiv
	import tceu_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire md_req_t               req,
	input  wire logic [DATA_WIDTH-1:0] x,
	input  wire logic [DATA_WIDTH-1:0] y,
	output logic                       done,
	output logic      [DATA_WIDTH-1:0] result
);

	localparam int DW = DATA_WIDTH;
	localparam int CW = $clog2(DW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic          is_div_q;
	logic          neg_q;
	logic [DW-1:0] rem_q;  // remainder, or product accumulator
	logic [DW-1:0] quo_q;  // dividend / quotient, or multiplier
	logic [DW-1:0] dvs_q;  // divisor, or multiplicand
	logic [DW:0]   rem_shift;
	logic [DW:0]   diff;

	assign rem_shift = {rem_q, quo_q[DW-1]};
	assign diff      = rem_shift - {1'b0, dvs_q};

	assign done   = done_q;
	assign result = is_div_q ? (neg_q ? DW'(-quo_q) : quo_q) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			is_div_q <= req.is_div;
			rem_q    <= '0;
			if (req.is_div) begin
				// work on magnitudes, sign fixed at the end
				neg_q <= x[DW-1] ^ y[DW-1];
				quo_q <= x[DW-1] ? DW'(-x) : x;
				dvs_q <= y[DW-1] ? DW'(-y) : y;
			end else begin
				neg_q <= 1'b0;
				quo_q <= y;
				dvs_q <= x;
			end
		end else if (busy_q) begin
			if (is_div_q) begin
				if (!diff[DW]) begin
					rem_q <= diff[DW-1:0];
					quo_q <= {quo_q[DW-2:0], 1'b1};
				end else begin
					rem_q <= rem_shift[DW-1:0];
					quo_q <= {quo_q[DW-2:0], 1'b0};
				end
			end else begin
				if (quo_q[0]) begin
					rem_q <= rem_q + dvs_q;
				end
				quo_q <= quo_q >> 1;
				dvs_q <= dvs_q << 1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/tceu_back.sv @@
// ----------------------------------------------------------------------------
// tceu_back
// Sequencer that reads operands, computes, writes state and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tceu_back
	import tceu_pkg::*;
#(
	parameter int REG_COUNT      = REG_COUNT_DEF,
	parameter int DATA_MEM_DEPTH = DATA_MEM_DEPTH_DEF,
	parameter int DATA_WIDTH     = DATA_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	output logic             q_ready,
	input  wire cmd_t        q_cmd,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       out_outcome,
	output logic [7:0]       out_target,
	output logic signed [31:0] out_value
);

	localparam int DW = DATA_WIDTH;
	localparam int RW = $clog2(REG_COUNT);
	localparam int MW = $clog2(DATA_MEM_DEPTH);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_RD1  = 7'b0000010,
		ST_RD2  = 7'b0000100,
		ST_RD3  = 7'b0001000,
		ST_CALC = 7'b0010000,
		ST_WAIT = 7'b0100000,
		ST_WB   = 7'b1000000
	} state_t;

	state_t                  state_q;
	state_t                  state_d;
	cmd_t                    cmd_q;
	logic [DW-1:0]           x_q;
	logic [DW-1:0]           y_q;
	logic [DW-1:0]           r_q;
	logic                    rd_ok_q;
	logic [REG_COUNT-1:0]    rf_valid_q;
	logic [DATA_MEM_DEPTH-1:0] mem_valid_q;

	logic                    rf_we;
	logic                    rf_re;
	logic [RW-1:0]           rf_raddr;
	logic [DW-1:0]           rf_rdata;
	logic                    mem_we;
	logic                    mem_re;
	logic [DW-1:0]           mem_rdata;
	logic [DW-1:0]           rd_data;
	logic                    commit;
	logic [1:0]              wb_outcome;
	logic [7:0]              wb_target;
	logic                    divz;
	md_req_t                 md_req;
	logic                    md_done;
	logic [DW-1:0]           md_result;
	logic                    rd1_ok;

	tceu_ram #(
		.WIDTH (DW),
		.DEPTH (REG_COUNT)
	) u_rf (
		.clk   (clk),
		.we    (rf_we),
		.waddr (cmd_q.d[RW-1:0]),
		.wdata (r_q),
		.re    (rf_re),
		.raddr (rf_raddr),
		.rdata (rf_rdata)
	);

	tceu_ram #(
		.WIDTH (DW),
		.DEPTH (DATA_MEM_DEPTH)
	) u_dmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cmd_q.addr[MW-1:0]),
		.wdata (r_q),
		.re    (mem_re),
		.raddr (cmd_q.addr[MW-1:0]),
		.rdata (mem_rdata)
	);

	tceu_muldiv #(
		.DATA_WIDTH (DW)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.x      (x_q),
		.y      (y_q),
		.done   (md_done),
		.result (md_result)
	);

	assign q_ready = state_q == ST_IDLE;
	assign divz    = (cmd_q.kind == K_ALU) && (cmd_q.alu == ALU_DIV) && (y_q == '0);

	// read port use: first operand in rd1, second register operand in rd2
	always_comb begin
		rf_re    = 1'b0;
		mem_re   = 1'b0;
		rf_raddr = cmd_q.a[RW-1:0];
		rd1_ok   = 1'b0;
		if (state_q == ST_RD1) begin
			case (cmd_q.kind)
				K_LOAD: begin
					mem_re = cmd_q.addr_ok;
					rd1_ok = cmd_q.addr_ok && mem_valid_q[cmd_q.addr[MW-1:0]];
				end
				K_STORE: begin
					rf_re    = cmd_q.d_ok;
					rf_raddr = cmd_q.d[RW-1:0];
					rd1_ok   = cmd_q.d_ok && rf_valid_q[cmd_q.d[RW-1:0]];
				end
				default: begin
					rf_re  = cmd_q.a_ok;
					rd1_ok = cmd_q.a_ok && rf_valid_q[cmd_q.a[RW-1:0]];
				end
			endcase
		end else if (state_q == ST_RD2) begin
			rf_re    = cmd_q.b_ok;
			rf_raddr = cmd_q.b[RW-1:0];
		end
	end

	// never written entries and out of range indexes read as zero
	assign rd_data = !rd_ok_q ? '0 : ((cmd_q.kind == K_LOAD) ? mem_rdata : rf_rdata);

	always_comb begin
		wb_outcome = OUT_NONE;
		wb_target  = '0;
		rf_we      = 1'b0;
		mem_we     = 1'b0;
		commit     = (state_q == ST_WB) && (!out_valid || out_ready);
		case (cmd_q.kind)
			K_PRELOAD, K_STORE: begin
				if (cmd_q.addr_ok) begin
					wb_outcome = OUT_MEM;
					wb_target  = cmd_q.addr;
					mem_we     = commit;
				end
			end
			K_LOAD: begin
				if (cmd_q.d_ok) begin
					wb_outcome = OUT_REG;
					wb_target  = {4'b0, cmd_q.d};
					rf_we      = commit;
				end
			end
			K_ALU: begin
				if (divz) begin
					wb_outcome = OUT_DIVZ;
					wb_target  = {4'b0, cmd_q.d};
				end else if (cmd_q.d_ok) begin
					wb_outcome = OUT_REG;
					wb_target  = {4'b0, cmd_q.d};
					rf_we      = commit;
				end
			end
			default: begin
				wb_outcome = OUT_NONE;
			end
		endcase
	end

	always_comb begin
		state_d       = state_q;
		md_req.start  = 1'b0;
		md_req.is_div = cmd_q.alu == ALU_DIV;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_cmd.kind inside {K_LOAD, K_STORE, K_ALU}) begin
						state_d = ST_RD1;
					end else begin
						state_d = ST_WB;
					end
				end
			end
			ST_RD1: begin
				state_d = ST_RD2;
			end
			ST_RD2: begin
				state_d = (cmd_q.kind == K_ALU) ? ST_RD3 : ST_WB;
			end
			ST_RD3: begin
				state_d = ST_CALC;
			end
			ST_CALC: begin
				if (cmd_q.alu == ALU_MUL || (cmd_q.alu == ALU_DIV && !divz)) begin
					md_req.start = 1'b1;
					state_d      = ST_WAIT;
				end else begin
					state_d = ST_WB;
				end
			end
			ST_WAIT: begin
				if (md_done) begin
					state_d = ST_WB;
				end
			end
			ST_WB: begin
				if (commit) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid   <= 1'b0;
			rf_valid_q  <= '0;
			mem_valid_q <= '0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (rf_we) begin
				rf_valid_q[cmd_q.d[RW-1:0]] <= 1'b1;
			end
			if (mem_we) begin
				mem_valid_q[cmd_q.addr[MW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q <= q_cmd;
				r_q   <= DW'(q_cmd.value);
			end
			ST_RD1: begin
				rd_ok_q <= rd1_ok;
			end
			ST_RD2: begin
				x_q     <= rd_data;
				r_q     <= rd_data;
				rd_ok_q <= cmd_q.b_ok && rf_valid_q[cmd_q.b[RW-1:0]];
			end
			ST_RD3: begin
				y_q <= rd_data;
			end
			ST_CALC: begin
				r_q <= (cmd_q.alu == ALU_SUB) ? x_q - y_q : x_q + y_q;
			end
			ST_WAIT: begin
				if (md_done) begin
					r_q <= md_result;
				end
			end
			default: begin
			end
		endcase
		if (commit) begin
			out_outcome <= wb_outcome;
			out_target  <= wb_target;
			out_value   <= (wb_outcome inside {OUT_REG, OUT_MEM}) ?
			               32'(signed'(r_q)) : '0;
		end
	end

endmodule

`default_nettype wire

@@ rtl/toy_cpu_execute_unit_core.sv @@
// ----------------------------------------------------------------------------
// toy_cpu_execute_unit_core
// Execute stage of a small cpu with its own register file and data memory.
// ----------------------------------------------------------------------------
// Items enter through a decode register and a two-entry queue, so the input
// keeps flowing while the back end works and while a result waits in the
// output register, until those fill. The back end handles one item at a time.
// Preload and no-op items go from idle straight to write-back; load and store
// first pass the read states RD1 and RD2; add, subtract and division by zero
// pass RD1 to RD3 and the calc state; multiply and divide then also wait on
// the shared multiply / divide unit, which retires one bit a cycle.
// The register file and data memory are single read port RAMs, so the two
// register operands are fetched in successive cycles; per-entry valid flops
// make both stores read as zero after reset with no clearing pass.
`default_nettype none

module toy_cpu_execute_unit_core
	import tceu_pkg::*;
#(
	parameter int REG_COUNT      = REG_COUNT_DEF,
	parameter int DATA_MEM_DEPTH = DATA_MEM_DEPTH_DEF,
	parameter int DATA_WIDTH     = DATA_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // instr[15:0], load_addr[23:16], load_value[55:24]
	input  wire logic [0:0]  s_tuser,  // func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,  // target[7:0], value[39:8]
	output logic [1:0]       m_tuser   // outcome
);

	logic               push_valid;
	logic               push_ready;
	cmd_t               push_cmd;
	logic               q_valid;
	logic               q_ready;
	cmd_t               q_cmd;
	logic [7:0]         out_target;
	logic signed [31:0] out_value;

	tceu_front #(
		.REG_COUNT      (REG_COUNT),
		.DATA_MEM_DEPTH (DATA_MEM_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	tceu_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_cmd    (push_cmd),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_cmd   (q_cmd)
	);

	tceu_back #(
		.REG_COUNT      (REG_COUNT),
		.DATA_MEM_DEPTH (DATA_MEM_DEPTH),
		.DATA_WIDTH     (DATA_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_ready     (q_ready),
		.q_cmd       (q_cmd),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_outcome (m_tuser),
		.out_target  (out_target),
		.out_value   (out_value)
	);

	assign m_tdata = {out_value, out_target};

endmodule

`default_nettype wire

@@ rtl/tceu_checker.sv @@
// ----------------------------------------------------------------------------
// tceu_checker
// Port level checks of the execute unit result stream, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tceu_checker
	import tceu_pkg::*;
#(
	parameter int REG_COUNT = REG_COUNT_DEF
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	else $error("result changed while stalled");

	// an item with no effect carries zero target and value
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == OUT_NONE |-> m_tdata == '0)
	else $error("no-effect item with non-zero payload");

	// division by zero writes nothing and reports zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == OUT_DIVZ |-> m_tdata[39:8] == '0 && m_tdata[7:4] == '0)
	else $error("division by zero item with bad payload");

	// register writes only hit existing registers
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == OUT_REG |-> {1'b0, m_tdata[7:0]} < 9'(REG_COUNT))
	else $error("register write outside the register file");

endmodule

bind toy_cpu_execute_unit_core tceu_checker #(
	.REG_COUNT (REG_COUNT)
) u_tceu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

@@ dv/toy_cpu_execute_unit_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// toy_cpu_execute_unit_core_tb
// Self-checking bench for the execute stage: register file and data memory
// are tracked alongside the block, every item's write-back is predicted and
// compared in order, with bursty input traffic and a stalling result side.
// ----------------------------------------------------------------------------

module toy_cpu_execute_unit_core_tb;
	import tceu_pkg::*;

	localparam int RANDOM_ITEMS = 650;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_CYCLES  = 300;

	// five of the opcodes the block treats as no-ops
	localparam logic [3:0] SPARE_OPS [5] = '{4'h0, 4'h3, 4'h4, 4'h9, 4'hF};

	typedef struct packed {
		logic [1:0]         outcome;
		logic [7:0]         target;
		logic signed [31:0] value;
	} write_back_t;

	// tracks the architectural state and the write-backs still owed
	class cpu_state_tracker;
		logic signed [31:0] regs [16];
		logic signed [31:0] mem [256];
		write_back_t        due [$];
		int                 mismatches;

		function new();
			foreach (regs[i]) regs[i] = '0;
			foreach (mem[i]) mem[i] = '0;
			mismatches = 0;
		endfunction

		function void take_item(logic func, logic [15:0] instr, logic [7:0] laddr,
				logic signed [31:0] lval);
			logic [3:0]         op, d, a, b;
			logic [7:0]         addr;
			logic signed [31:0] x, y, w;
			longint             q;
			write_back_t        r;
			op   = instr[15:12];
			d    = instr[11:8];
			a    = instr[7:4];
			b    = instr[3:0];
			addr = instr[7:0];
			r    = '0;
			if (func == FUNC_PRELOAD) begin
				mem[laddr] = lval;
				r.outcome  = OUT_MEM;
				r.target   = laddr;
				r.value    = lval;
			end else begin
				case (op)
					OP_LOAD: begin
						regs[d]   = mem[addr];
						r.outcome = OUT_REG;
						r.target  = {4'd0, d};
						r.value   = mem[addr];
					end
					OP_STORE: begin
						mem[addr] = regs[d];
						r.outcome = OUT_MEM;
						r.target  = addr;
						r.value   = regs[d];
					end
					OP_ADD, OP_SUB, OP_DIV, OP_MUL: begin
						x = regs[a];
						y = regs[b];
						if (op == OP_DIV && y == 0) begin
							r.outcome = OUT_DIVZ;
							r.target  = {4'd0, d};
						end else begin
							case (op)
								OP_ADD: w = x + y;
								OP_SUB: w = x - y;
								OP_MUL: w = x * y;
								default: begin
									// 64-bit quotient so min / -1 wraps rather than traps
									q = longint'(x) / longint'(y);
									w = q[31:0];
								end
							endcase
							regs[d]   = w;
							r.outcome = OUT_REG;
							r.target  = {4'd0, d};
							r.value   = w;
						end
					end
					default: r = '0;
				endcase
			end
			due.push_back(r);
		endfunction

		task flag_mismatch(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task match_result(logic [1:0] outcome, logic [7:0] target, logic signed [31:0] value);
			write_back_t e;
			if (due.size() == 0) begin
				flag_mismatch($sformatf("unexpected item outcome=%0d target=%0d value=%0d",
					outcome, target, value));
			end else begin
				e = due.pop_front();
				if (outcome !== e.outcome)
					flag_mismatch($sformatf("outcome %0d, expected %0d", outcome, e.outcome));
				if (target !== e.target)
					flag_mismatch($sformatf("target %0d, expected %0d", target, e.target));
				if (value !== e.value)
					flag_mismatch($sformatf("value %0d, expected %0d", value, e.value));
			end
		endtask
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata  = '0;  // instr[15:0], load_addr[23:16], load_value[55:24]
	logic [0:0]  s_tuser  = '0;  // func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // target[7:0], value[39:8]
	logic [1:0]  m_tuser;        // outcome

	cpu_state_tracker tracker = new();
	int items_in    = 0;
	int idle_cycles = 0;

	toy_cpu_execute_unit_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// offer one item and hold it until the block takes it
	task automatic send_item(input logic func, input logic [15:0] instr,
			input logic [7:0] laddr, input logic [31:0] lval);
		s_tuser  <= func;
		s_tdata  <= {lval, laddr, instr};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		tracker.take_item(func, instr, laddr, lval);
		items_in++;
	endtask

	function automatic logic [31:0] rand_word();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			return 32'($signed($urandom_range(0, 32)) - 16);
		if (pick < 40) begin
			case ($urandom_range(0, 4))
				0: return 32'h0000_0000;
				1: return 32'hFFFF_FFFF;
				2: return 32'h8000_0000;
				3: return 32'h7FFF_FFFF;
				default: return 32'h0000_0001;
			endcase
		end
		return $urandom();
	endfunction

	function automatic logic [7:0] rand_addr();
		// favour a small window so loads mostly hit preloaded words
		if ($urandom_range(0, 1))
			return 8'($urandom_range(0, 15));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic random_item();
		int          pick;
		logic [3:0]  op;
		logic [15:0] instr;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			send_item(FUNC_PRELOAD, 16'($urandom()), rand_addr(), rand_word());
		end else begin
			if (pick < 30)
				op = OP_LOAD;
			else if (pick < 40)
				op = OP_STORE;
			else if (pick < 52)
				op = OP_ADD;
			else if (pick < 64)
				op = OP_SUB;
			else if (pick < 78)
				op = OP_DIV;
			else if (pick < 90)
				op = OP_MUL;
			else
				op = SPARE_OPS[$urandom_range(0, 4)];
			if (op == OP_LOAD || op == OP_STORE)
				instr = {op, 4'($urandom_range(0, 15)), rand_addr()};
			else
				instr = {op, 12'($urandom())};
			// preload fields carry junk on execute items
			send_item(FUNC_EXEC, instr, 8'($urandom()), $urandom());
		end
	endtask

	// result side: stretches of differing stall patterns, plus one long hold
	initial begin
		int mode, span, k;
		bit held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			if (!held && items_in >= 150) begin
				held = 1'b1;
				for (k = 0; k < HOLD_CYCLES; k++) begin
					@(posedge clk);
					m_tready <= 1'b0;
				end
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 60);
			for (k = 0; k < span; k++) begin
				@(posedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= k[0];
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.match_result(m_tuser, m_tdata[7:0], m_tdata[39:8]);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		int left, burst, gap, i;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes into memory, then into registers
		send_item(FUNC_PRELOAD, 16'hFFFF, 8'd0,   32'h7FFF_FFFF);
		send_item(FUNC_PRELOAD, 16'h0000, 8'd255, 32'h8000_0000);
		send_item(FUNC_PRELOAD, 16'hA5A5, 8'd1,   32'hFFFF_FFFF);
		send_item(FUNC_PRELOAD, 16'h5A5A, 8'd3,   32'hFFFF_FFF9);
		send_item(FUNC_PRELOAD, 16'h0000, 8'd4,   32'h0000_0002);
		send_item(FUNC_EXEC, {OP_LOAD, 4'd1,  8'd0},   8'hFF, 32'hFFFF_FFFF);
		send_item(FUNC_EXEC, {OP_LOAD, 4'd15, 8'd255}, 8'h00, 32'h0000_0000);
		send_item(FUNC_EXEC, {OP_LOAD, 4'd2,  8'd1},   8'h00, 32'h0000_0000);
		send_item(FUNC_EXEC, {OP_LOAD, 4'd9,  8'd3},   8'h00, 32'h0000_0000);
		send_item(FUNC_EXEC, {OP_LOAD, 4'd10, 8'd4},   8'h00, 32'h0000_0000);
		// add and subtract wrap, multiply of large values
		send_item(FUNC_EXEC, {OP_ADD, 4'd3, 4'd1,  4'd1}, 8'h00, 32'h0);
		send_item(FUNC_EXEC, {OP_SUB, 4'd4, 4'd15, 4'd1}, 8'h00, 32'h0);
		send_item(FUNC_EXEC, {OP_MUL, 4'd7, 4'd1,  4'd1}, 8'h00, 32'h0);
		send_item(FUNC_EXEC, {OP_MUL, 4'd8, 4'd2,  4'd15}, 8'h00, 32'h0);
		// most negative over minus one, zero divisor, negative truncation
		send_item(FUNC_EXEC, {OP_DIV, 4'd5,  4'd15, 4'd2},  8'h00, 32'h0);
		send_item(FUNC_EXEC, {OP_DIV, 4'd6,  4'd1,  4'd0},  8'h00, 32'h0);
		send_item(FUNC_EXEC, {OP_DIV, 4'd11, 4'd9,  4'd10}, 8'h00, 32'h0);
		// stores to address 200 and the top end of memory, and a read back
		send_item(FUNC_EXEC, {OP_STORE, 4'd15, 8'd200}, 8'h00, 32'h0);
		send_item(FUNC_EXEC, {OP_STORE, 4'd3,  8'd255}, 8'h00, 32'h0);
		send_item(FUNC_EXEC, {OP_LOAD,  4'd12, 8'd200}, 8'h00, 32'h0);
		for (i = 0; i < 5; i++)
			send_item(FUNC_EXEC, {SPARE_OPS[i], 12'($urandom())}, 8'h00, 32'h0);

		left = RANDOM_ITEMS;
		while (left > 0) begin
			burst = $urandom_range(1, 30);
			if (burst > left)
				burst = left;
			for (i = 0; i < burst; i++)
				random_item();
			left -= burst;
			if ($urandom_range(0, 2) != 0) begin
				gap = $urandom_range(1, 12);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;

		while (tracker.due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.mismatches == 0 && tracker.due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ files.f @@
rtl/tceu_pkg.sv
rtl/tceu_ram.sv
rtl/tceu_front.sv
rtl/tceu_fifo.sv
rtl/tceu_muldiv.sv
rtl/tceu_back.sv
rtl/toy_cpu_execute_unit_core.sv
rtl/tceu_checker.sv
dv/toy_cpu_execute_unit_core_tb.sv
